>>> rtl/thps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thps_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 4096;
    localparam int LINE_DEPTH  = 8192;
    localparam int HANN_TABLE  = 1024;
    localparam int HANN_BITS   = $clog2(HANN_TABLE);
    localparam int FRAC_BITS   = 16;
    localparam int STEP_BITS   = 18;
    localparam int WIN_BITS    = 28;
    localparam int MIX_BITS    = 17;
    localparam int GAIN_BITS   = 17;
    localparam int W_BITS      = WIN_BITS + 1;
    localparam int INT_BITS    = WIN_BITS - FRAC_BITS;
    localparam int CNT_BITS    = 5;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = WIN_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_STEP = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX     = 2'd2;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 28'd65536000;
    localparam logic [WIN_BITS-1:0] ONE_SAMPLE   = 28'd65536;
    localparam logic [W_BITS-1:0]   MAX_W        = W_BITS'(MAX_WINDOW * 65536);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          block_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          block_end_out;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       add;
        logic       fix;
        logic       mod_init;
        logic       mod_step;
        logic       heads;
        logic       div_step;
        logic       gain;
        logic       rd;
        logic [1:0] rd_sel;
        logic       cap;
        logic [1:0] cap_sel;
        logic       mul1;
        logic       mul2;
        logic       mix;
        logic       out_load;
        logic       pass_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
        logic fix_done;
        logic fix_long;
    } dp_stat_t;

    typedef logic [GAIN_BITS-1:0] hann_rom_t [HANN_TABLE];

    // Hann gain 0.5 * (1 - cos(2 pi k / N)) in Q1.16 via a Q30 Taylor series.
    function automatic hann_rom_t build_hann();
        hann_rom_t         rom;
        longint unsigned   a2;
        longint unsigned   theta;
        longint unsigned   t2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        logic              neg;
        for (int k = 0; k < HANN_TABLE; k++) begin
            a2  = 64'(2 * k);
            neg = 1'b0;
            if (a2 > 64'(HANN_TABLE)) begin
                a2 = 64'(2 * HANN_TABLE) - a2;
            end
            if (2 * a2 > 64'(HANN_TABLE)) begin
                a2  = 64'(HANN_TABLE) - a2;
                neg = 1'b1;
            end
            theta = (64'd3373259426 * a2) / 64'(HANN_TABLE);
            t2    = (theta * theta) >> 30;
            term  = 64'd1073741824;
            sum   = 64'sd1073741824;
            for (int i = 1; i <= 8; i++) begin
                term = (term * t2) >> 30;
                term = term / 64'((2 * i - 1) * (2 * i));
                if ((i % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (neg) begin
                sum = -sum;
            end
            v = 64'sd1073741824 - sum;
            if (v < 0) begin
                v = 0;
            end
            rom[k] = GAIN_BITS'((v + 64'sd16384) >>> 15);
        end
        return rom;
    endfunction

    localparam hann_rom_t HANN_ROM = build_hann();

endpackage

`default_nettype wire

>>> rtl/two_head_pitch_shifter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-head delay-line pitch shifter, one stereo frame per item.
// Input channel s_valid/s_ready/s_data carries left, right and block end;
// result channel m_valid/m_ready/m_data returns one processed frame per item.
// Configuration: write cfg_wr_en with cfg_index (0 offset step, 1 window,
// 2 wet mix) and cfg_wr_data; write only while no item is in flight.
// Sequence: a frame with a window of one sample or less is passed through
// dry and loaded into the output register by the pass state once the
// register is free. Otherwise an item runs through the add, fix, heads,
// bit-serial gain index division, four reads on each delay line port,
// capture, two multiply, mix and output states before its result is loaded
// into the output register. A step that pulls the offset below zero makes
// the fix state add the window until the offset lies in range. After a
// window shrink that leaves the offset far outside the window, the offset
// is reduced bit-serially in the modulo state before the heads are formed.
// One item is processed at a time; the next item is taken as soon as the
// previous result sits in the output register.
// Reset clears configuration to its defaults, the read offset and the write
// pointer; line entries not yet written since reset read as zero.
// A stalled receiver holds the result in the output register; a finished
// item then waits in the controller until the register frees up.
module two_head_pitch_shifter_core
    import thps_pkg::*;
#(
    parameter int LINE_DEPTH_P = LINE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each item through the datapath
    thps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // offset arithmetic, delay lines, interpolation, gains and mix
    thps_dp #(.DEPTH(LINE_DEPTH_P)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

    // one item at a time: an accepted item blocks the next until done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item was in flight");

    // a fresh result only appears after an item was being processed
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without an item in flight");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

>>> rtl/thps_line.sv
`timescale 1ns / 1ps
`default_nettype none

module thps_line
    import thps_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic signed [SAMPLE_BITS-1:0] wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic signed [SAMPLE_BITS-1:0]      rdata
);

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/thps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module thps_ctrl
    import thps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PASS = 4'd1;
    localparam logic [3:0] ST_ADD  = 4'd2;
    localparam logic [3:0] ST_FIX  = 4'd3;
    localparam logic [3:0] ST_MOD  = 4'd4;
    localparam logic [3:0] ST_HEAD = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_RD0  = 4'd7;
    localparam logic [3:0] ST_RD1  = 4'd8;
    localparam logic [3:0] ST_RD2  = 4'd9;
    localparam logic [3:0] ST_RD3  = 4'd10;
    localparam logic [3:0] ST_CAP  = 4'd11;
    localparam logic [3:0] ST_MUL1 = 4'd12;
    localparam logic [3:0] ST_MUL2 = 4'd13;
    localparam logic [3:0] ST_MIX  = 4'd14;
    localparam logic [3:0] ST_OUT  = 4'd15;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = stat.bypass ? ST_PASS : ST_ADD;
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    cmd.pass_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix = 1'b1;
                if (stat.fix_done) begin
                    state_next = ST_HEAD;
                end else if (stat.fix_long) begin
                    cmd.mod_init = 1'b1;
                    cnt_next     = CNT_BITS'(W_BITS - 1);
                    state_next   = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cmd.heads  = 1'b1;
                cnt_next   = CNT_BITS'(HANN_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.gain   = 1'b1;
                cmd.rd     = 1'b1;
                cmd.rd_sel = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd      = 1'b1;
                cmd.rd_sel  = 2'd1;
                cmd.cap     = 1'b1;
                cmd.cap_sel = 2'd0;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd      = 1'b1;
                cmd.rd_sel  = 2'd2;
                cmd.cap     = 1'b1;
                cmd.cap_sel = 2'd1;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd      = 1'b1;
                cmd.rd_sel  = 2'd3;
                cmd.cap     = 1'b1;
                cmd.cap_sel = 2'd2;
                state_next  = ST_CAP;
            end
            ST_CAP: begin
                cmd.cap     = 1'b1;
                cmd.cap_sel = 2'd3;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load || cmd.pass_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/thps_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module thps_dp
    import thps_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  wire in_item_t                 s_data,
    output out_item_t                     m_data,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat
);

    localparam int AW = $clog2(DEPTH);

    // configuration
    logic signed [STEP_BITS-1:0] step_reg;
    logic [WIN_BITS-1:0]         win_reg;
    logic [MIX_BITS-1:0]         mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            win_reg  <= WINDOW_RESET;
            mix_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFFSET_STEP: step_reg <= cfg_wr_data[STEP_BITS-1:0];
                REG_WINDOW:      win_reg  <= cfg_wr_data[WIN_BITS-1:0];
                REG_WET_MIX:     mix_reg  <= cfg_wr_data[MIX_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [W_BITS-1:0] wl_ext, w_eff;
    logic [W_BITS:0]   w30, w2;
    assign wl_ext = {1'b0, win_reg};
    assign w_eff  = (wl_ext > MAX_W) ? MAX_W : wl_ext;
    assign w30    = {1'b0, w_eff};
    assign w2     = {w_eff, 1'b0};

    // input frame
    logic signed [SAMPLE_BITS-1:0] dry_l_reg, dry_r_reg;
    logic                          end_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dry_l_reg <= s_data.left_in;
            dry_r_reg <= s_data.right_in;
            end_reg   <= s_data.block_end_in;
        end
    end

    // read offset and its reduction into [0, W)
    logic [WIN_BITS-1:0]      ro_reg, ro_next;
    logic signed [W_BITS:0]   v_reg, v_next;
    logic [W_BITS-1:0]        sh_reg, sh_next;
    logic                     v_neg, v_lt_w, v_lt_2w;
    logic [W_BITS-1:0]        r2;
    logic [W_BITS-1:0]        r2_red;

    assign v_neg   = v_reg[W_BITS];
    assign v_lt_w  = !v_neg && ($unsigned(v_reg) < w30);
    assign v_lt_2w = !v_neg && ($unsigned(v_reg) < w2);
    assign r2      = {ro_reg, sh_reg[W_BITS-1]};
    assign r2_red  = (r2 >= w_eff) ? (r2 - w_eff) : r2;

    assign stat.bypass   = (win_reg <= ONE_SAMPLE);
    assign stat.fix_done = v_lt_2w;
    assign stat.fix_long = !v_neg && !v_lt_2w;

    always_comb begin
        ro_next = ro_reg;
        v_next  = v_reg;
        sh_next = sh_reg;
        if (cmd.add) begin
            v_next = $signed({2'b00, ro_reg})
                   + $signed({{(W_BITS + 1 - STEP_BITS){step_reg[STEP_BITS-1]}}, step_reg});
        end
        if (cmd.fix) begin
            if (v_neg) begin
                v_next = v_reg + $signed(w30);
            end else if (v_lt_w) begin
                ro_next = v_reg[WIN_BITS-1:0];
            end else if (v_lt_2w) begin
                ro_next = WIN_BITS'($unsigned(v_reg) - w30);
            end
        end
        if (cmd.mod_init) begin
            ro_next = '0;
            sh_next = v_reg[W_BITS-1:0];
        end
        if (cmd.mod_step) begin
            ro_next = r2_red[WIN_BITS-1:0];
            sh_next = {sh_reg[W_BITS-2:0], 1'b0};
        end
    end

    // heads and gain index division
    logic [WIN_BITS-1:0]  half, xb, xb_reg;
    logic [WIN_BITS-1:0]  rem_a_reg, rem_b_reg;
    logic [HANN_BITS-1:0] q_a_reg, q_b_reg;
    logic [W_BITS-1:0]    t_a, t_b;
    logic                 ge_a, ge_b;

    assign half = w_eff[W_BITS-1:1];
    assign xb   = (ro_reg < half) ? (ro_reg + half) : (ro_reg - half);
    assign t_a  = {rem_a_reg, 1'b0};
    assign t_b  = {rem_b_reg, 1'b0};
    assign ge_a = (t_a >= w_eff);
    assign ge_b = (t_b >= w_eff);

    always_ff @(posedge aclk) begin
        v_reg  <= v_next;
        sh_reg <= sh_next;
        if (cmd.heads) begin
            xb_reg    <= xb;
            rem_a_reg <= ro_reg;
            rem_b_reg <= xb;
            q_a_reg   <= '0;
            q_b_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_a_reg <= ge_a ? WIN_BITS'(t_a - w_eff) : t_a[WIN_BITS-1:0];
            rem_b_reg <= ge_b ? WIN_BITS'(t_b - w_eff) : t_b[WIN_BITS-1:0];
            q_a_reg   <= {q_a_reg[HANN_BITS-2:0], ge_a};
            q_b_reg   <= {q_b_reg[HANN_BITS-2:0], ge_b};
        end
    end

    logic [GAIN_BITS-1:0] ga_reg, gb_reg;
    always_ff @(posedge aclk) begin
        if (cmd.gain) begin
            ga_reg <= HANN_ROM[q_a_reg];
            gb_reg <= HANN_ROM[q_b_reg];
        end
    end

    // write pointer; unwritten entries read as zero until the line wraps
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ro_reg      <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            ro_reg <= ro_next;
            if (cmd.out_load) begin
                wp_reg <= wp_reg + 1'b1;
                if (wp_reg == {AW{1'b1}}) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    logic [INT_BITS-1:0] i_sel;
    logic [AW-1:0]       raddr;
    logic                rd_ok, rd_ok_reg;

    always_comb begin
        i_sel = (cmd.rd_sel[1]) ? xb_reg[WIN_BITS-1:FRAC_BITS]
                                : ro_reg[WIN_BITS-1:FRAC_BITS];
        raddr = wp_reg - AW'(i_sel) - AW'(cmd.rd_sel[0]);
        rd_ok = wrapped_reg || (raddr <= wp_reg);
    end

    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_ok;
    end

    logic signed [SAMPLE_BITS-1:0] rd_l, rd_r;

    thps_line #(.DEPTH(DEPTH)) u_line_l (
        .aclk  (aclk),
        .we    (cmd.heads),
        .waddr (wp_reg),
        .wdata (dry_l_reg),
        .raddr (raddr),
        .rdata (rd_l)
    );

    thps_line #(.DEPTH(DEPTH)) u_line_r (
        .aclk  (aclk),
        .we    (cmd.heads),
        .waddr (wp_reg),
        .wdata (dry_r_reg),
        .raddr (raddr),
        .rdata (rd_r)
    );

    // taps: 0 = head A newer, 1 = head A older, 2 = head B newer, 3 = head B older
    logic signed [SAMPLE_BITS-1:0] s_l [4];
    logic signed [SAMPLE_BITS-1:0] s_r [4];

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            s_l[cmd.cap_sel] <= rd_ok_reg ? rd_l : '0;
            s_r[cmd.cap_sel] <= rd_ok_reg ? rd_r : '0;
        end
    end

    localparam int P1_BITS  = SAMPLE_BITS + 2 + FRAC_BITS;
    localparam int TAP_BITS = P1_BITS;
    localparam int P2_BITS  = TAP_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS = P2_BITS + 1;
    localparam int WET_BITS = ACC_BITS - 32;
    localparam int DIF_BITS = WET_BITS + 1;
    localparam int M_BITS   = DIF_BITS + MIX_BITS + 1;
    localparam int O_BITS   = M_BITS - 16 + 1;

    logic signed [FRAC_BITS:0]  fa, fb;
    logic signed [SAMPLE_BITS:0] d_la, d_lb, d_ra, d_rb;
    assign fa   = $signed({1'b0, ro_reg[FRAC_BITS-1:0]});
    assign fb   = $signed({1'b0, xb_reg[FRAC_BITS-1:0]});
    assign d_la = $signed({s_l[1][SAMPLE_BITS-1], s_l[1]})
                - $signed({s_l[0][SAMPLE_BITS-1], s_l[0]});
    assign d_lb = $signed({s_l[3][SAMPLE_BITS-1], s_l[3]})
                - $signed({s_l[2][SAMPLE_BITS-1], s_l[2]});
    assign d_ra = $signed({s_r[1][SAMPLE_BITS-1], s_r[1]})
                - $signed({s_r[0][SAMPLE_BITS-1], s_r[0]});
    assign d_rb = $signed({s_r[3][SAMPLE_BITS-1], s_r[3]})
                - $signed({s_r[2][SAMPLE_BITS-1], s_r[2]});

    logic signed [P1_BITS-1:0] p1_la_reg, p1_lb_reg, p1_ra_reg, p1_rb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            p1_la_reg <= P1_BITS'(d_la * fa);
            p1_lb_reg <= P1_BITS'(d_lb * fb);
            p1_ra_reg <= P1_BITS'(d_ra * fa);
            p1_rb_reg <= P1_BITS'(d_rb * fb);
        end
    end

    function automatic logic signed [TAP_BITS-1:0] tap_value(
        input logic signed [SAMPLE_BITS-1:0] s0,
        input logic signed [P1_BITS-1:0]     p
    );
        logic signed [TAP_BITS-1:0] base;
        base = TAP_BITS'(s0) <<< FRAC_BITS;
        return base + p;
    endfunction

    logic signed [TAP_BITS-1:0]  tap_la, tap_lb, tap_ra, tap_rb;
    logic signed [GAIN_BITS:0]   ga_s, gb_s;
    logic signed [P2_BITS-1:0]   p2_la_reg, p2_lb_reg, p2_ra_reg, p2_rb_reg;

    assign tap_la = tap_value(s_l[0], p1_la_reg);
    assign tap_lb = tap_value(s_l[2], p1_lb_reg);
    assign tap_ra = tap_value(s_r[0], p1_ra_reg);
    assign tap_rb = tap_value(s_r[2], p1_rb_reg);
    assign ga_s   = $signed({1'b0, ga_reg});
    assign gb_s   = $signed({1'b0, gb_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            p2_la_reg <= P2_BITS'(tap_la * ga_s);
            p2_lb_reg <= P2_BITS'(tap_lb * gb_s);
            p2_ra_reg <= P2_BITS'(tap_ra * ga_s);
            p2_rb_reg <= P2_BITS'(tap_rb * gb_s);
        end
    end

    function automatic logic signed [DIF_BITS-1:0] wet_minus_dry(
        input logic signed [P2_BITS-1:0]     pa,
        input logic signed [P2_BITS-1:0]     pb,
        input logic signed [SAMPLE_BITS-1:0] dry
    );
        logic signed [ACC_BITS-1:0] acc;
        logic signed [WET_BITS-1:0] wet;
        acc = ACC_BITS'(pa) + ACC_BITS'(pb) + $signed(ACC_BITS'(64'd2147483648));
        wet = WET_BITS'(acc >>> 32);
        return DIF_BITS'(wet) - DIF_BITS'(dry);
    endfunction

    logic signed [DIF_BITS-1:0] dif_l, dif_r;
    logic signed [MIX_BITS:0]   mix_s;
    logic signed [M_BITS-1:0]   m_l_reg, m_r_reg;

    assign dif_l = wet_minus_dry(p2_la_reg, p2_lb_reg, dry_l_reg);
    assign dif_r = wet_minus_dry(p2_ra_reg, p2_rb_reg, dry_r_reg);
    assign mix_s = $signed({1'b0, mix_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mix) begin
            m_l_reg <= M_BITS'(dif_l * mix_s);
            m_r_reg <= M_BITS'(dif_r * mix_s);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] blend_sat(
        input logic signed [M_BITS-1:0]      m,
        input logic signed [SAMPLE_BITS-1:0] dry
    );
        logic signed [M_BITS-1:0] rnd;
        logic signed [O_BITS-1:0] o;
        rnd = m + $signed(M_BITS'(32768));
        o   = O_BITS'(rnd >>> 16) + O_BITS'(dry);
        if (o > $signed(O_BITS'((1 << (SAMPLE_BITS - 1)) - 1))) begin
            return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end else if (o < -$signed(O_BITS'(1 << (SAMPLE_BITS - 1)))) begin
            return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end
        return o[SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data.left_out      <= blend_sat(m_l_reg, dry_l_reg);
            m_data.right_out     <= blend_sat(m_r_reg, dry_r_reg);
            m_data.block_end_out <= end_reg;
        end else if (cmd.pass_load) begin
            m_data.left_out      <= dry_l_reg;
            m_data.right_out     <= dry_r_reg;
            m_data.block_end_out <= end_reg;
        end
    end

endmodule

`default_nettype wire
